// File: hw/rtl/sklt_pkg.sv
// Shared types and constants for the sorted key/value lookup table.
// Used by sklt_cell and sorted_key_value_lookup_table_top; no dependencies.
`default_nettype none

package sklt_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_LOAD     = 2'd1,
    CMD_FIND_KEY = 2'd2,
    CMD_FIND_VAL = 2'd3
  } cmd_e;

  // Search word walking down the row of cells.
  typedef struct packed {
    logic                     valid;
    logic                     by_value;
    logic signed [DATA_W-1:0] probe;
    logic                     found;
    logic signed [DATA_W-1:0] result;
  } token_t;

endpackage

`default_nettype wire

// File: hw/rtl/sorted_key_value_lookup_table_top.sv
// Sorted key/value lookup table: a row of TABLE_DEPTH cells kept in key order.
// Clear and load register their result word at the accept edge, and a new word can be
// taken every cycle. Finds walk a search word down the row, one cell per cycle while no
// waiting result holds the row; the input is stalled until the find's result word is
// registered, so a new word is not taken while a find is in the row.
// A result word still waiting stalls the input. Reset clears the count and control state.
`default_nettype none

module sorted_key_value_lookup_table_top import sklt_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_stall_o,
  input  wire logic [1:0]               command_i,
  input  wire logic signed [DATA_W-1:0] key_in_i,
  input  wire logic signed [DATA_W-1:0] value_in_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_stall_i,
  output      logic                     found_o,
  output      logic signed [DATA_W-1:0] key_out_o,
  output      logic signed [DATA_W-1:0] value_out_o,
  output      logic                     status_o
);

  logic [CNT_W-1:0]         count_q, count_d;
  logic                     busy_q, busy_d;
  logic                     out_valid_q, out_valid_d;
  logic                     found_q, found_d;
  logic signed [DATA_W-1:0] key_out_q, key_out_d;
  logic signed [DATA_W-1:0] value_out_q, value_out_d;
  logic                     status_q, status_d;

  cmd_e                     cmd;
  logic                     in_acc;
  logic                     out_free;
  logic                     full;
  logic                     ins_en;
  logic                     adv;
  logic                     tok_done;

  logic [TABLE_DEPTH-1:0]   occupied;
  logic [TABLE_DEPTH-1:0]   stay;
  logic [TABLE_DEPTH-1:0]   left_stay;
  logic [TABLE_DEPTH-1:0]   tok_valid;
  logic signed [DATA_W-1:0] cell_key   [TABLE_DEPTH];
  logic signed [DATA_W-1:0] cell_value [TABLE_DEPTH];
  logic signed [DATA_W-1:0] left_key   [TABLE_DEPTH];
  logic signed [DATA_W-1:0] left_value [TABLE_DEPTH];
  token_t                   tok        [TABLE_DEPTH+1];
  token_t                   launch_tok;
  token_t                   last_tok;

  assign cmd      = cmd_e'(command_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy_q || !out_free;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign full     = (count_q == CNT_W'(TABLE_DEPTH));
  assign ins_en   = in_acc && (cmd == CMD_LOAD) && !full;

  assign last_tok = tok[TABLE_DEPTH];
  assign tok_done = last_tok.valid && out_free;
  // Hold the row while the finished search word cannot leave.
  assign adv      = !last_tok.valid || out_free;

  // Launch a search word into the first cell on an accepted find.
  always_comb begin
    launch_tok          = '0;
    launch_tok.valid    = in_acc && (cmd == CMD_FIND_KEY || cmd == CMD_FIND_VAL);
    launch_tok.by_value = (cmd == CMD_FIND_VAL);
    launch_tok.probe    = (cmd == CMD_FIND_VAL) ? value_in_i : key_in_i;
  end

  assign tok[0] = launch_tok;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign occupied[i] = (CNT_W'(i) < count_q);
    assign tok_valid[i] = tok[i+1].valid;
    if (i == 0) begin : g_head
      assign left_stay[i]  = 1'b1;
      assign left_key[i]   = key_in_i;
      assign left_value[i] = value_in_i;
    end else begin : g_body
      assign left_stay[i]  = stay[i-1];
      assign left_key[i]   = cell_key[i-1];
      assign left_value[i] = cell_value[i-1];
    end

    sklt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .occupied_i  (occupied[i]),
      .ins_en_i    (ins_en),
      .new_key_i   (key_in_i),
      .new_value_i (value_in_i),
      .left_stay_i (left_stay[i]),
      .left_key_i  (left_key[i]),
      .left_value_i(left_value[i]),
      .stay_o      (stay[i]),
      .key_o       (cell_key[i]),
      .value_o     (cell_value[i]),
      .adv_i       (adv),
      .tok_i       (tok[i]),
      .tok_o       (tok[i+1])
    );
  end

  always_comb begin
    count_d     = count_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q && out_stall_i;
    found_d     = found_q;
    key_out_d   = key_out_q;
    value_out_d = value_out_q;
    status_d    = status_q;
    if (in_acc) begin
      case (cmd)
        CMD_CLEAR, CMD_LOAD: begin
          out_valid_d = 1'b1;
          found_d     = 1'b0;
          key_out_d   = '0;
          value_out_d = '0;
          status_d    = (cmd == CMD_LOAD) && full;
          if (cmd == CMD_CLEAR) begin
            count_d = '0;
          end else if (!full) begin
            count_d = count_q + CNT_W'(1);
          end
        end
        default: begin
          busy_d = 1'b1;
        end
      endcase
    end
    if (tok_done) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      found_d     = last_tok.found;
      key_out_d   = last_tok.by_value ? last_tok.result : '0;
      value_out_d = last_tok.by_value ? '0 : last_tok.result;
      status_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q     <= found_d;
    key_out_q   <= key_out_d;
    value_out_q <= value_out_d;
    status_q    <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign key_out_o   = key_out_q;
  assign value_out_o = value_out_q;
  assign status_o    = status_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_one_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_valid))
    else $error("more than one search word in the row");

  a_busy_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (|tok_valid))
    else $error("busy flag and search word disagree");

  a_count_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> $stable(count_q))
    else $error("entry count changed during a search");

endmodule

`default_nettype wire

// File: hw/rtl/sklt_cell.sv
// One storage cell of the sorted table: holds a key/value pair, shifts it on
// insert and checks the passing search word. Depends on sklt_pkg.
`default_nettype none

module sklt_cell import sklt_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     occupied_i,
  input  wire logic                     ins_en_i,
  input  wire logic signed [DATA_W-1:0] new_key_i,
  input  wire logic signed [DATA_W-1:0] new_value_i,
  input  wire logic                     left_stay_i,
  input  wire logic signed [DATA_W-1:0] left_key_i,
  input  wire logic signed [DATA_W-1:0] left_value_i,
  output      logic                     stay_o,
  output      logic signed [DATA_W-1:0] key_o,
  output      logic signed [DATA_W-1:0] value_o,
  input  wire logic                     adv_i,
  input  wire token_t                   tok_i,
  output      token_t                   tok_o
);

  logic signed [DATA_W-1:0] key_q, key_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  token_t                   tok_q, tok_d;
  logic                     match;

  // Keep the entry if the new key does not sort before it (stable insert).
  assign stay_o  = occupied_i && !(new_key_i < key_q);
  assign key_o   = key_q;
  assign value_o = value_q;

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    if (ins_en_i && !stay_o) begin
      if (left_stay_i) begin
        key_d   = new_key_i;
        value_d = new_value_i;
      end else begin
        key_d   = left_key_i;
        value_d = left_value_i;
      end
    end
  end

  assign match = tok_i.by_value ? (value_q == tok_i.probe) : (key_q == tok_i.probe);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.found && occupied_i && match) begin
      tok_d.found  = 1'b1;
      tok_d.result = tok_i.by_value ? key_q : value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire
